/* rtl/core/alfwm_pkg.sv */
// ----------------------------------------------------------------------------
// alfwm_pkg
// Shared types and constants for the admission limited fifo wait meter.
// ----------------------------------------------------------------------------
package alfwm_pkg;

	localparam int DEPTH_DEF = 64;
	localparam int ID_W      = 16;
	localparam int TIME_W    = 32;
	localparam int OCC_W     = 7;
	localparam int CNT_W     = 16;
	localparam int SUM_W     = 48;
	localparam int STAT_W    = 3;
	localparam int ADDR_W    = 3;

	localparam logic [OCC_W-1:0] CAP_RESET   = 7'd64;
	localparam logic [CNT_W-1:0] LIMIT_RESET = 16'hffff;

	typedef enum logic [STAT_W-1:0] {
		ST_ENQUEUED = 3'd0,
		ST_REFUSED  = 3'd1,
		ST_DROPPED  = 3'd2,
		ST_DEQUEUED = 3'd3,
		ST_EMPTY    = 3'd4,
		ST_FINISHED = 3'd5
	} status_t;

	typedef enum logic [0:0] {
		REG_CAPACITY = 1'b0,
		REG_LIMIT    = 1'b1
	} reg_idx_t;

	typedef enum logic [0:0] {
		OP_ENQ = 1'b0,
		OP_DEQ = 1'b1
	} op_t;

	typedef struct packed {
		logic [ID_W-1:0]   id;
		logic [TIME_W-1:0] stamp;
	} entry_t;

	typedef struct packed {
		logic [OCC_W-1:0] capacity;
		logic [CNT_W-1:0] limit;
	} cfg_t;

endpackage

/* rtl/core/alfwm_cell.sv */
// ----------------------------------------------------------------------------
// alfwm_cell
// One queue slot: loads an arriving item or takes its upper neighbor's
// entry when the head is removed.
// ----------------------------------------------------------------------------
module alfwm_cell (
	input  logic            clk,
	input  logic            load,
	input  logic            shift,
	input  alfwm_pkg::entry_t load_data,
	input  alfwm_pkg::entry_t next_data,
	output alfwm_pkg::entry_t data_q
);

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= load_data;
		end else if (shift) begin
			data_q <= next_data;
		end
	end

endmodule

/* rtl/core/alfwm_cfg.sv */
// ----------------------------------------------------------------------------
// alfwm_cfg
// Configuration registers behind the APB port: capacity and arrival limit.
// ----------------------------------------------------------------------------
module alfwm_cfg (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [alfwm_pkg::ADDR_W-1:0]   paddr,
	input  logic [31:0]                    pwdata,
	output logic [31:0]                    prdata,
	output logic                           pready,
	output alfwm_pkg::cfg_t                cfg
);

	alfwm_pkg::cfg_t     cfg_q;
	alfwm_pkg::reg_idx_t idx;
	logic                wr_en;

	assign pready = 1'b1;
	assign idx    = alfwm_pkg::reg_idx_t'(paddr[2]);
	assign wr_en  = psel & penable & pwrite & pready;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.capacity <= alfwm_pkg::CAP_RESET;
			cfg_q.limit    <= alfwm_pkg::LIMIT_RESET;
		end else if (wr_en) begin
			unique case (idx)
				alfwm_pkg::REG_CAPACITY: cfg_q.capacity <= pwdata[alfwm_pkg::OCC_W-1:0];
				alfwm_pkg::REG_LIMIT:    cfg_q.limit    <= pwdata[alfwm_pkg::CNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (idx)
			alfwm_pkg::REG_CAPACITY: prdata = 32'(cfg_q.capacity);
			alfwm_pkg::REG_LIMIT:    prdata = 32'(cfg_q.limit);
			default:                 prdata = '0;
		endcase
	end

endmodule

/* rtl/core/admission_limited_fifo_wait_meter.sv */
// ----------------------------------------------------------------------------
// admission_limited_fifo_wait_meter
// Bounded fifo of item ids with entry stamps, built as a row of shifting
// cells; reports wait time, occupancy, head/tail ids and running counters.
// ----------------------------------------------------------------------------
// the result of an item is registered and strobed on done in the cycle after start
// throughput: one item per cycle, busy stays low; enqueue loads the cell at
// the occupancy index, dequeue shifts the whole row one cell toward the head
// reset clears occupancy, counters, wait sum and registers; cell contents are
// left as they are and are never read before written
// ----------------------------------------------------------------------------
module admission_limited_fifo_wait_meter #(
	parameter int DEPTH = alfwm_pkg::DEPTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic                              opcode,
	input  logic [alfwm_pkg::ID_W-1:0]        item_id,
	input  logic [alfwm_pkg::TIME_W-1:0]      now_time,
	output logic                              done,
	output logic [alfwm_pkg::STAT_W-1:0]      status,
	output logic [alfwm_pkg::ID_W-1:0]        out_id,
	output logic [alfwm_pkg::TIME_W-1:0]      out_wait_time,
	output logic [alfwm_pkg::OCC_W-1:0]       occupancy_now,
	output logic [alfwm_pkg::ID_W-1:0]        head_id,
	output logic [alfwm_pkg::ID_W-1:0]        tail_id,
	output logic [alfwm_pkg::CNT_W-1:0]       tried_total,
	output logic [alfwm_pkg::CNT_W-1:0]       added_total,
	output logic [alfwm_pkg::CNT_W-1:0]       removed_total,
	output logic [alfwm_pkg::SUM_W-1:0]       wait_sum,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [alfwm_pkg::ADDR_W-1:0]      paddr,
	input  logic [31:0]                       pwdata,
	output logic [31:0]                       prdata,
	output logic                              pready
);

	localparam int IW   = $clog2(DEPTH) + 1;
	localparam int CMPW = (IW > alfwm_pkg::OCC_W) ? IW : alfwm_pkg::OCC_W;
	localparam int OW   = alfwm_pkg::OCC_W;
	localparam int CW   = alfwm_pkg::CNT_W;
	localparam int SW   = alfwm_pkg::SUM_W;

	alfwm_pkg::cfg_t   cfg;
	alfwm_pkg::entry_t cells [DEPTH];
	alfwm_pkg::entry_t next_of [DEPTH];
	alfwm_pkg::entry_t in_entry;
	logic [DEPTH-1:0]  load_vec;

	logic [OW-1:0]           occ_q;
	logic [CW-1:0]           tried_q;
	logic [CW-1:0]           added_q;
	logic [CW-1:0]           removed_q;
	logic [SW-1:0]           acc_q;
	logic [alfwm_pkg::ID_W-1:0] tail_q;

	logic                    is_deq;
	logic                    limit_hit;
	logic                    full;
	logic                    enq_store;
	logic                    deq_do;
	logic [CMPW-1:0]         eff_cap;
	logic [alfwm_pkg::TIME_W-1:0] wait_t;
	logic [SW:0]             acc_add;
	logic [SW-1:0]           acc_next;
	logic [OW-1:0]           occ_next;
	logic [CW-1:0]           tried_next;
	alfwm_pkg::status_t      st;
	logic [alfwm_pkg::ID_W-1:0] oid;
	logic [alfwm_pkg::ID_W-1:0] head_next;
	logic [alfwm_pkg::ID_W-1:0] tail_next;

	logic                    done_s1;
	alfwm_pkg::status_t      status_s1;
	logic [alfwm_pkg::ID_W-1:0] oid_s1;
	logic [alfwm_pkg::TIME_W-1:0] wait_s1;
	logic [alfwm_pkg::ID_W-1:0] head_s1;
	logic [alfwm_pkg::ID_W-1:0] tail_s1;

	alfwm_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	assign busy           = 1'b0;
	assign in_entry.id    = item_id;
	assign in_entry.stamp = now_time;
	assign is_deq         = (alfwm_pkg::op_t'(opcode) == alfwm_pkg::OP_DEQ);

	// capacity above the cell count is clamped to it
	assign eff_cap   = (CMPW'(cfg.capacity) > CMPW'(DEPTH)) ? CMPW'(DEPTH)
	                                                         : CMPW'(cfg.capacity);
	assign limit_hit = (tried_q >= cfg.limit);
	assign full      = (CMPW'(occ_q) >= eff_cap);
	assign enq_store = start && !is_deq && !limit_hit && !full;
	assign deq_do    = start && is_deq && (occ_q != '0);

	genvar gi;
	generate
		for (gi = 0; gi < DEPTH; gi++) begin : g_cell
			assign load_vec[gi] = enq_store && (IW'(occ_q) == IW'(gi));
			if (gi == DEPTH - 1) begin : g_last
				assign next_of[gi] = cells[gi];
			end else begin : g_mid
				assign next_of[gi] = cells[gi+1];
			end
			alfwm_cell u_cell (
				.clk       (clk),
				.load      (load_vec[gi]),
				.shift     (deq_do),
				.load_data (in_entry),
				.next_data (next_of[gi]),
				.data_q    (cells[gi])
			);
		end
	endgenerate

	assign wait_t   = now_time - cells[0].stamp;
	assign acc_add  = {1'b0, acc_q} + (SW+1)'(wait_t);
	assign acc_next = acc_add[SW] ? {SW{1'b1}} : acc_add[SW-1:0];

	always_comb begin
		st         = alfwm_pkg::ST_EMPTY;
		oid        = '0;
		occ_next   = occ_q;
		tried_next = tried_q;
		if (!is_deq) begin
			if (limit_hit) begin
				st  = alfwm_pkg::ST_REFUSED;
				oid = item_id;
			end else begin
				tried_next = tried_q + CW'(1);
				if (full) begin
					st  = alfwm_pkg::ST_DROPPED;
					oid = item_id;
				end else begin
					st       = alfwm_pkg::ST_ENQUEUED;
					occ_next = occ_q + OW'(1);
				end
			end
		end else if (occ_q == '0) begin
			st = limit_hit ? alfwm_pkg::ST_FINISHED : alfwm_pkg::ST_EMPTY;
		end else begin
			st       = alfwm_pkg::ST_DEQUEUED;
			oid      = cells[0].id;
			occ_next = occ_q - OW'(1);
		end
	end

	// head and tail as seen after this item
	always_comb begin
		if (occ_next == '0) begin
			head_next = '0;
		end else if (deq_do) begin
			head_next = cells[1].id;
		end else if (enq_store && (occ_q == '0)) begin
			head_next = item_id;
		end else begin
			head_next = cells[0].id;
		end
		if (enq_store) begin
			tail_next = item_id;
		end else if (occ_next == '0) begin
			tail_next = '0;
		end else begin
			tail_next = tail_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q     <= '0;
			tried_q   <= '0;
			added_q   <= '0;
			removed_q <= '0;
			acc_q     <= '0;
			done_s1   <= 1'b0;
		end else begin
			done_s1 <= start;
			if (start) begin
				occ_q   <= occ_next;
				tried_q <= tried_next;
			end
			if (enq_store) begin
				added_q <= added_q + CW'(1);
			end
			if (deq_do) begin
				removed_q <= removed_q + CW'(1);
				acc_q     <= acc_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (enq_store) begin
			tail_q <= item_id;
		end
		if (start) begin
			status_s1 <= st;
			oid_s1    <= oid;
			wait_s1   <= deq_do ? wait_t : '0;
			head_s1   <= head_next;
			tail_s1   <= tail_next;
		end
	end

	assign done          = done_s1;
	assign status        = status_s1;
	assign out_id        = oid_s1;
	assign out_wait_time = wait_s1;
	assign occupancy_now = occ_q;
	assign head_id       = head_s1;
	assign tail_id       = tail_s1;
	assign tried_total   = tried_q;
	assign added_total   = added_q;
	assign removed_total = removed_q;
	assign wait_sum      = acc_q;

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the admission limited fifo wait meter. A shadow
// queue with its own counters predicts every result; directed cases cover
// empty reads, stamp wrap, capacity edges and the arrival limit, then random
// phases mix traffic shapes and register settings with bursts of idle cycles.
// ----------------------------------------------------------------------------
module tb;
	import alfwm_pkg::*;

	localparam int QDEPTH = DEPTH_DEF;
	localparam int PTR_W = $clog2(DEPTH_DEF);
	localparam logic [SUM_W-1:0] SUM_MAX = '1;
	localparam int RANDOM_ITEMS = 1900;
	localparam int REPORT_LIMIT = 10;

	typedef struct {
		status_t           st;
		logic [ID_W-1:0]   oid;
		logic [TIME_W-1:0] sojourn;
		logic [OCC_W-1:0]  occ;
		logic [ID_W-1:0]   head;
		logic [ID_W-1:0]   tail;
		logic [CNT_W-1:0]  tried;
		logic [CNT_W-1:0]  added;
		logic [CNT_W-1:0]  removed;
		logic [SUM_W-1:0]  sum;
	} fifo_result_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic               busy;
	logic               opcode = 1'b0;
	logic [ID_W-1:0]    item_id = '0;
	logic [TIME_W-1:0]  now_time = '0;
	logic               done;
	logic [STAT_W-1:0]  status;
	logic [ID_W-1:0]    out_id;
	logic [TIME_W-1:0]  out_wait_time;
	logic [OCC_W-1:0]   occupancy_now;
	logic [ID_W-1:0]    head_id;
	logic [ID_W-1:0]    tail_id;
	logic [CNT_W-1:0]   tried_total;
	logic [CNT_W-1:0]   added_total;
	logic [CNT_W-1:0]   removed_total;
	logic [SUM_W-1:0]   wait_sum;
	logic               psel = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite = 1'b0;
	logic [ADDR_W-1:0]  paddr = '0;
	logic [31:0]        pwdata = '0;
	logic [31:0]        prdata;
	logic               pready;

	// shadow of the queue and its counters
	logic [ID_W-1:0]    shadow_ids [QDEPTH];
	logic [TIME_W-1:0]  shadow_stamps [QDEPTH];
	logic [PTR_W-1:0]   head_ptr = '0;
	logic [PTR_W-1:0]   tail_ptr = '0;
	logic [OCC_W-1:0]   held = '0;
	logic [CNT_W-1:0]   tried_cnt = '0;
	logic [CNT_W-1:0]   added_cnt = '0;
	logic [CNT_W-1:0]   removed_cnt = '0;
	logic [SUM_W-1:0]   sojourn_sum = '0;
	logic [OCC_W-1:0]   cap_reg = CAP_RESET;
	logic [CNT_W-1:0]   limit_reg = LIMIT_RESET;

	fifo_result_t       pending_results [$];
	int unsigned        mismatch_count = 0;
	logic [TIME_W-1:0]  clock_us = '0;

	admission_limited_fifo_wait_meter u_top (.*);

	always #5 clk = ~clk;

	task automatic check_field(input string field, input logic [63:0] want,
			input logic [63:0] got);
		if (got !== want) begin
			mismatch_count++;
			if (mismatch_count <= REPORT_LIMIT)
				$display("mismatch on %s: expected %0h, got %0h", field, want, got);
		end
	endtask

	task automatic predict_queue_step(input op_t op, input logic [ID_W-1:0] id,
			input logic [TIME_W-1:0] stamp);
		fifo_result_t r;
		logic [OCC_W-1:0] eff_cap;
		eff_cap = (cap_reg > QDEPTH) ? OCC_W'(QDEPTH) : cap_reg;
		r.oid = '0;
		r.sojourn = '0;
		if (op == OP_ENQ) begin
			if (tried_cnt >= limit_reg) begin
				r.st = ST_REFUSED;
				r.oid = id;
			end else begin
				tried_cnt++;
				if (held >= eff_cap) begin
					r.st = ST_DROPPED;
					r.oid = id;
				end else begin
					shadow_ids[tail_ptr] = id;
					shadow_stamps[tail_ptr] = stamp;
					tail_ptr++;
					held++;
					added_cnt++;
					r.st = ST_ENQUEUED;
				end
			end
		end else if (held == 0) begin
			r.st = (tried_cnt >= limit_reg) ? ST_FINISHED : ST_EMPTY;
		end else begin
			r.oid = shadow_ids[head_ptr];
			r.sojourn = stamp - shadow_stamps[head_ptr];
			head_ptr++;
			held--;
			removed_cnt++;
			if (SUM_MAX - sojourn_sum < SUM_W'(r.sojourn))
				sojourn_sum = SUM_MAX;
			else
				sojourn_sum += SUM_W'(r.sojourn);
			r.st = ST_DEQUEUED;
		end
		r.occ = held;
		r.head = (held != 0) ? shadow_ids[head_ptr] : '0;
		r.tail = (held != 0) ? shadow_ids[PTR_W'(tail_ptr - 1'b1)] : '0;
		r.tried = tried_cnt;
		r.added = added_cnt;
		r.removed = removed_cnt;
		r.sum = sojourn_sum;
		pending_results.push_back(r);
	endtask

	// result checker: the block strobes each result for one cycle
	always @(posedge clk) begin
		fifo_result_t r;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= REPORT_LIMIT)
					$display("unexpected result, status %0d id %0h", status, out_id);
			end else begin
				r = pending_results.pop_front();
				check_field("status", r.st, status);
				check_field("out_id", r.oid, out_id);
				check_field("out_wait_time", r.sojourn, out_wait_time);
				check_field("occupancy_now", r.occ, occupancy_now);
				check_field("head_id", r.head, head_id);
				check_field("tail_id", r.tail, tail_id);
				check_field("tried_total", r.tried, tried_total);
				check_field("added_total", r.added, added_total);
				check_field("removed_total", r.removed, removed_total);
				check_field("wait_sum", r.sum, wait_sum);
			end
		end
	end

	task automatic send_item(input op_t op, input logic [ID_W-1:0] id,
			input logic [TIME_W-1:0] stamp);
		start <= 1'b1;
		opcode <= op;
		item_id <= id;
		now_time <= stamp;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		predict_queue_step(op, id, stamp);
	endtask

	task automatic pause(input int unsigned hold_cycles);
		start <= 1'b0;
		repeat (hold_cycles)
			@(posedge clk);
	endtask

	task automatic drain_results();
		start <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	// write then read back; only called with nothing in flight
	task automatic write_reg(input reg_idx_t idx, input int unsigned value);
		logic [31:0] want;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		if (idx == REG_CAPACITY)
			cap_reg = OCC_W'(value);
		else
			limit_reg = CNT_W'(value);
		want = (idx == REG_CAPACITY) ? 32'(cap_reg) : 32'(limit_reg);
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		check_field("prdata", want, prdata);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic test_empty_and_wrap();
		send_item(OP_DEQ, 16'h0000, 32'h0);
		send_item(OP_ENQ, 16'h0000, 32'h0000_0000);
		send_item(OP_ENQ, 16'hffff, 32'hffff_ffff);
		send_item(OP_ENQ, 16'h5a5a, 32'h8000_0000);
		send_item(OP_DEQ, 16'hffff, 32'h0000_0005);
		// stamp wrapped past zero
		send_item(OP_DEQ, 16'h0000, 32'h0000_0003);
		send_item(OP_DEQ, 16'ha5a5, 32'h8000_0000);
		send_item(OP_DEQ, 16'h0000, 32'h0000_0000);
		send_item(OP_ENQ, 16'h1234, 32'h0000_0001);
		send_item(OP_DEQ, 16'h0000, 32'h0000_0000);
		drain_results();
	endtask

	task automatic test_capacity_edges();
		write_reg(REG_CAPACITY, 1);
		send_item(OP_ENQ, 16'h0101, 32'h100);
		send_item(OP_ENQ, 16'h0202, 32'h200);
		send_item(OP_DEQ, 16'h0000, 32'h300);
		drain_results();
		write_reg(REG_CAPACITY, 0);
		send_item(OP_ENQ, 16'h0303, 32'h400);
		send_item(OP_DEQ, 16'h0000, 32'h500);
		drain_results();
		// above the depth acts as the depth
		write_reg(REG_CAPACITY, 127);
		send_item(OP_ENQ, 16'h0404, 32'h600);
		send_item(OP_ENQ, 16'h0505, 32'h700);
		send_item(OP_DEQ, 16'h0000, 32'h800);
		send_item(OP_DEQ, 16'h0000, 32'h900);
		drain_results();
		write_reg(REG_CAPACITY, QDEPTH);
	endtask

	task automatic test_arrival_limit();
		write_reg(REG_LIMIT, int'(tried_cnt) + 2);
		send_item(OP_ENQ, 16'h0a0a, 32'h1000);
		send_item(OP_ENQ, 16'h0b0b, 32'h1100);
		send_item(OP_ENQ, 16'h0c0c, 32'h1200);
		send_item(OP_DEQ, 16'h0000, 32'h1300);
		send_item(OP_DEQ, 16'h0000, 32'h1400);
		send_item(OP_DEQ, 16'h0000, 32'h1500);
		drain_results();
		// lowered below what was already counted
		write_reg(REG_LIMIT, 0);
		send_item(OP_ENQ, 16'h0d0d, 32'h1600);
		send_item(OP_DEQ, 16'h0000, 32'h1700);
		drain_results();
		write_reg(REG_LIMIT, 16'hffff);
		send_item(OP_ENQ, 16'h0e0e, 32'h1800);
		send_item(OP_DEQ, 16'h0000, 32'h1900);
		drain_results();
	endtask

	task automatic test_random_traffic();
		int unsigned sent;
		int unsigned phase_len;
		int unsigned enq_pct;
		int unsigned cap_val;
		int unsigned limit_val;
		bit gaps_on;
		op_t op;
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			drain_results();
			case ($urandom_range(0, 19))
				0, 1:         cap_val = 0;
				2, 3, 4:      cap_val = $urandom_range(1, 3);
				5, 6, 7:      cap_val = $urandom_range(65, 127);
				8, 9, 10, 11: cap_val = QDEPTH;
				default:      cap_val = $urandom_range(1, QDEPTH);
			endcase
			case ($urandom_range(0, 9))
				0:       limit_val = 0;
				1:       limit_val = $urandom_range(0, 65535);
				2, 3:    limit_val = int'(tried_cnt) + $urandom_range(0, 40);
				default: limit_val = 65535;
			endcase
			if ($urandom_range(0, 1)) begin
				write_reg(REG_CAPACITY, cap_val);
				write_reg(REG_LIMIT, limit_val);
			end else begin
				write_reg(REG_LIMIT, limit_val);
				write_reg(REG_CAPACITY, cap_val);
			end
			phase_len = $urandom_range(20, 150);
			case ($urandom_range(0, 2))
				0:       enq_pct = 85;
				1:       enq_pct = 50;
				default: enq_pct = 15;
			endcase
			gaps_on = ($urandom_range(0, 2) != 0);
			repeat (phase_len) begin
				// the tail of the run goes without idle cycles
				if (gaps_on && sent + 300 < RANDOM_ITEMS && $urandom_range(0, 3) == 0)
					pause($urandom_range(1, 18));
				case ($urandom_range(0, 11))
					0:       clock_us = $urandom;
					1:       clock_us = 32'hffff_ffff - $urandom_range(0, 50);
					2:       clock_us += $urandom;
					default: clock_us += $urandom_range(0, 1000);
				endcase
				op = ($urandom_range(1, 100) <= enq_pct) ? OP_ENQ : OP_DEQ;
				send_item(op, ID_W'($urandom), clock_us);
				sent++;
			end
		end
	endtask

	initial begin
		repeat (10)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_and_wrap();
		test_capacity_edges();
		test_arrival_limit();
		test_random_traffic();
		drain_results();
		repeat (4)
			@(posedge clk);
		if (mismatch_count == 0 && pending_results.size() == 0) begin
			$display("admission_limited_fifo_wait_meter test passed");
		end else begin
			$display("admission_limited_fifo_wait_meter test failed");
		end
		$finish;
	end

	initial begin
		#5_000_000;
		$display("admission_limited_fifo_wait_meter test failed");
		$finish;
	end

endmodule

/* sim.f */
rtl/core/alfwm_pkg.sv
rtl/core/alfwm_cell.sv
rtl/core/alfwm_cfg.sv
rtl/core/admission_limited_fifo_wait_meter.sv
tb/sv/tb.sv
